// ===== hw/rtl/hhop_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhop_pkg
// Shared types and constants for the Hubbard hopping unit.
// ----------------------------------------------------------------------------
package hhop_pkg;

	// lattice size the table and the ports are built for
	localparam int MAX_SITES   = 8;
	localparam int TABLE_DEPTH = MAX_SITES * MAX_SITES;
	localparam int SITE_W      = $clog2(MAX_SITES + 1);
	localparam int OCC_W       = 2 * MAX_SITES;
	localparam int POS_W       = $clog2(OCC_W);

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_APPLY = 1'b1
	} opcode_t;

	// one hop result as it leaves the block
	typedef struct packed {
		logic [15:0]        new_occupation;
		logic signed [15:0] hop_amplitude;
		logic [2:0]         from_site;
		logic [2:0]         to_site;
		logic               spin;
		logic               found;
	} hop_t;

	localparam hop_t HOP_NONE = '0;

	localparam logic signed [15:0] AMP_MIN = 16'sh8000;
	localparam logic signed [15:0] AMP_MAX = 16'sh7fff;

endpackage

// ===== hw/rtl/hubbard_hop_with_fermion_sign_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hubbard_hop_with_fermion_sign_top
// Hopping term of a Hubbard Hamiltonian with Jordan-Wigner fermion sign.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken when start is high and busy low.
//   opcode OP_LOAD writes amplitude into table entry table_index (row*s+col)
//   and gives no result; busy stays low.
//   opcode OP_APPLY scans every site pair i<j of the occupation word. Each
//   pair costs one table read; a pair that hops for both spins stalls the
//   scan while its second result is parked. Busy stays high for the whole
//   scan; no pair is scanned when fewer than two sites are active.
//   Results leave on result_valid, one cycle each; the last one carries
//   last. The receiver cannot stall; each result is held back in a buffer
//   until the next one arrives, so that last can be attached. No hop at
//   all gives one result with found low.
//   Config channel: cfg_valid/cfg_ready write active_sites (always ready);
//   write it only while busy is low.
//   Reset: active_sites goes to 8 and a clearing pass zeroes all
//   MAX_SITES*MAX_SITES (64) entries of the amplitude table with busy high.
// ----------------------------------------------------------------------------
module hubbard_hop_with_fermion_sign_top
	import hhop_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// command channel
	input  logic               start,
	output logic               busy,
	input  logic               opcode,
	input  logic [15:0]        occupation,
	input  logic [5:0]         table_index,
	input  logic signed [15:0] amplitude,
	// config channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [3:0]         cfg_data,
	// result channel
	output logic               result_valid,
	output logic [15:0]        new_occupation,
	output logic signed [15:0] hop_amplitude,
	output logic [2:0]         from_site,
	output logic [2:0]         to_site,
	output logic               spin,
	output logic               found,
	output logic               last
);

	localparam int DEPTH = TABLE_DEPTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = SITE_W;
	localparam int EW    = OCC_W;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_SCAN  = 3'b100
	} state_t;

	state_t state_q;

	// amplitude table
	logic signed [15:0] mem [DEPTH];
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic signed [15:0] mem_wdata;
	logic [AW-1:0]      rd_addr;
	logic signed [15:0] amp_s1;

	logic [AW-1:0]      clr_cnt_q;
	logic [3:0]         sites_cfg_q;
	logic [SW-1:0]      sites;
	logic [15:0]        occ_q;

	// scan cursor
	logic [SW-1:0]      i_q;
	logic [SW-1:0]      j_q;
	logic [AW:0]        row_q;
	logic               scan_act_q;

	// evaluation stage
	logic               v_s1;
	logic [SW-1:0]      i_s1;
	logic [SW-1:0]      j_s1;
	hop_t               hop_dn;
	hop_t               hop_up;

	// result buffering
	logic               pend_v_q;
	hop_t               pend_q;
	logic               held_v_q;
	hop_t               held_q;
	hop_t               res_q;
	logic               res_valid_q;
	logic               last_q;

	logic               accept;
	logic               load_go;
	logic               scanning;
	logic               dn_found;
	logic               up_found;
	logic               new_v;
	hop_t               new_hop;
	logic               stall;
	logic               issue;
	logic               finish;
	logic               emit_v;
	hop_t               emit_hop;
	logic               row_end;
	logic               scan_end;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign load_go   = accept && (opcode == OP_LOAD) && (32'(table_index) < DEPTH);
	assign scanning  = (state_q == ST_SCAN);

	// active_sites above MAX_SITES acts as MAX_SITES
	assign sites = (32'(sites_cfg_q) > MAX_SITES) ? SW'(MAX_SITES) : SW'(sites_cfg_q);

	assign rd_addr  = AW'(row_q + (AW + 1)'(j_q));
	assign row_end  = (j_q == sites - SW'(1));
	assign scan_end = ((SW + 1)'(i_q) + (SW + 1)'(2)) >= (SW + 1)'(sites);

	// table write port: clearing pass or load
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_cnt_q;
		mem_wdata = '0;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (load_go) begin
			mem_we    = 1'b1;
			mem_waddr = AW'(table_index);
			mem_wdata = amplitude;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		amp_s1 <= mem[rd_addr];
	end

	hhop_eval u_eval_dn (
		.occ     (EW'(occ_q)),
		.sites   (sites),
		.site_i  (i_s1),
		.site_j  (j_s1),
		.spin_up (1'b0),
		.amp     (amp_s1),
		.hop     (hop_dn)
	);

	hhop_eval u_eval_up (
		.occ     (EW'(occ_q)),
		.sites   (sites),
		.site_i  (i_s1),
		.site_j  (j_s1),
		.spin_up (1'b1),
		.amp     (amp_s1),
		.hop     (hop_up)
	);

	// pick this cycle's new result; a double hop parks the up result and
	// squashes the read in flight so the cursor replays it
	always_comb begin
		dn_found = v_s1 && hop_dn.found;
		up_found = v_s1 && hop_up.found;
		new_v    = 1'b0;
		new_hop  = hop_dn;
		stall    = 1'b0;
		priority if (pend_v_q) begin
			new_v   = 1'b1;
			new_hop = pend_q;
		end else if (dn_found) begin
			new_v   = 1'b1;
			new_hop = hop_dn;
			stall   = up_found;
		end else if (up_found) begin
			new_v   = 1'b1;
			new_hop = hop_up;
		end
		issue  = scanning && scan_act_q && !stall;
		finish = scanning && !scan_act_q && !v_s1 && !pend_v_q;
		// held result goes out when a newer one arrives, or as last
		emit_v   = (scanning && new_v && held_v_q) || finish;
		emit_hop = held_q;
		if (finish && !held_v_q) begin
			emit_hop = HOP_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			sites_cfg_q <= 4'd8;
			i_q         <= '0;
			j_q         <= '0;
			row_q       <= '0;
			scan_act_q  <= 1'b0;
			v_s1        <= 1'b0;
			pend_v_q    <= 1'b0;
			held_v_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= emit_v;
			if (cfg_valid && cfg_ready) begin
				sites_cfg_q <= cfg_data;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (32'(clr_cnt_q) == DEPTH - 1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && opcode == OP_APPLY) begin
						state_q    <= ST_SCAN;
						i_q        <= '0;
						j_q        <= SW'(1);
						row_q      <= '0;
						scan_act_q <= (sites >= SW'(2));
						v_s1       <= 1'b0;
						pend_v_q   <= 1'b0;
						held_v_q   <= 1'b0;
					end
				end
				ST_SCAN: begin
					v_s1 <= issue;
					if (issue) begin
						if (row_end) begin
							if (scan_end) begin
								scan_act_q <= 1'b0;
							end else begin
								i_q   <= i_q + SW'(1);
								j_q   <= i_q + SW'(2);
								row_q <= row_q + (AW + 1)'(sites);
							end
						end else begin
							j_q <= j_q + SW'(1);
						end
					end
					pend_v_q <= stall;
					if (new_v) begin
						held_v_q <= 1'b1;
					end
					if (finish) begin
						held_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept && opcode == OP_APPLY) begin
			occ_q <= occupation;
		end
		i_s1 <= i_q;
		j_s1 <= j_q;
		if (stall) begin
			pend_q <= hop_up;
		end
		if (new_v) begin
			held_q <= new_hop;
		end
		if (emit_v) begin
			res_q  <= emit_hop;
			last_q <= finish;
		end
	end

	assign result_valid   = res_valid_q;
	assign new_occupation = res_q.new_occupation;
	assign hop_amplitude  = res_q.hop_amplitude;
	assign from_site      = res_q.from_site;
	assign to_site        = res_q.to_site;
	assign spin           = res_q.spin;
	assign found          = res_q.found;
	assign last           = last_q;

endmodule

// ===== hw/rtl/hhop_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhop_eval
// Hop test for one site pair and one spin: occupancy check, Jordan-Wigner
// parity of the orbitals in between, signed amplitude and flipped state.
// ----------------------------------------------------------------------------
module hhop_eval
	import hhop_pkg::*;
(
	input  logic [OCC_W-1:0]    occ,
	input  logic [SITE_W-1:0]   sites,
	input  logic [SITE_W-1:0]   site_i,
	input  logic [SITE_W-1:0]   site_j,
	input  logic                spin_up,
	input  logic signed [15:0]  amp,
	output hop_t                hop
);

	logic [POS_W-1:0]   base;
	logic [POS_W-1:0]   pos_i;
	logic [POS_W-1:0]   pos_j;
	logic               bit_i;
	logic               bit_j;
	logic [OCC_W-1:0]   one;
	logic [OCC_W-1:0]   below_hi;
	logic [OCC_W-1:0]   below_lo;
	logic [OCC_W-1:0]   flipped;
	logic               odd;
	logic signed [15:0] neg;

	always_comb begin
		one   = OCC_W'(1);
		base  = spin_up ? POS_W'(sites) : '0;
		// site 0 is the top bit of each half
		pos_j = POS_W'(sites) - POS_W'(site_j) - POS_W'(1) + base;
		pos_i = POS_W'(sites) - POS_W'(site_i) - POS_W'(1) + base;
		bit_j = occ[pos_j];
		bit_i = occ[pos_i];

		// orbitals strictly between pos_j and pos_i
		below_hi = (one << pos_i) - one;
		below_lo = ((one << pos_j) << 1) - one;
		odd      = ^(occ & below_hi & ~below_lo);

		neg     = (amp == AMP_MIN) ? AMP_MAX : -amp;
		flipped = occ ^ (one << pos_j) ^ (one << pos_i);

		hop.new_occupation = flipped[15:0];
		hop.hop_amplitude  = odd ? neg : amp;
		hop.from_site      = bit_j ? 3'(site_j) : 3'(site_i);
		hop.to_site        = bit_j ? 3'(site_i) : 3'(site_j);
		hop.spin           = spin_up;
		hop.found          = (bit_j != bit_i) && (amp != '0);
	end

endmodule

// ===== hw/rtl/hhop_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhop_checker
// Port-level checks for the Hubbard hopping unit, bound to the top level.
// ----------------------------------------------------------------------------
module hhop_checker
	import hhop_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic opcode,
	input logic result_valid,
	input logic found,
	input logic last
);

	// a load completes in the accepting cycle
	a_load_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (opcode == OP_LOAD) |=> !busy)
		else $error("load transaction left the block busy");

	// an apply always occupies the block
	a_apply_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (opcode == OP_APPLY) |=> busy)
		else $error("apply transaction did not raise busy");

	// a no-hop result must be the last result of its item
	a_none_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !found |-> last)
		else $error("no-hop result without last");

	// only the final result may appear after busy drops
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> busy)
		else $error("intermediate result while idle");

endmodule

bind hubbard_hop_with_fermion_sign_top hhop_checker u_hhop_checker (.*);

// ===== dv/hhop_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhop_monitor
// Watches the command, config and result channels of the hopping unit,
// predicts every hop result and compares it field by field.
// ----------------------------------------------------------------------------
module hhop_monitor
	import hhop_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic               opcode,
	input  logic [15:0]        occupation,
	input  logic [5:0]         table_index,
	input  logic signed [15:0] amplitude,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [3:0]         cfg_data,
	input  logic               result_valid,
	input  logic [15:0]        new_occupation,
	input  logic signed [15:0] hop_amplitude,
	input  logic [2:0]         from_site,
	input  logic [2:0]         to_site,
	input  logic               spin,
	input  logic               found,
	input  logic               last,
	output int                 hops_owed,
	output int                 hop_errors
);

	typedef struct packed {
		logic hop_t_pad;
	} unused_t;

	typedef struct packed {
		hop_t hop;
		logic last;
	} hop_result_t;

	logic signed [15:0] amp_table [MAX_SITES*MAX_SITES];
	logic [3:0]         sites_in_use;
	hop_result_t        hops_due [$];
	hop_result_t        got_hop;
	int                 errs;

	// append one predicted result at the tail of the queue
	function automatic void enqueue_hop(hop_result_t r);
		hops_due = {hops_due, r};
	endfunction

	// scan every pair i<j with a nonzero amplitude, down spin before up
	function automatic void predict_hops(logic [15:0] occ);
		int                 s;
		int                 i;
		int                 j;
		int                 k;
		int                 b;
		int                 bi;
		int                 bj;
		logic               odd;
		logic               held;
		logic signed [15:0] a;
		hop_result_t        r;
		hop_result_t        prev;
		s = (sites_in_use > MAX_SITES) ? MAX_SITES : int'(sites_in_use);
		held = 1'b0;
		prev = '0;
		for (i = 0; i < s; i++) begin
			for (j = i + 1; j < s; j++) begin
				a = amp_table[i*s+j];
				if (a == 0)
					continue;
				for (k = 0; k < 2; k++) begin
					bj = s - j - 1 + k*s;
					bi = s - i - 1 + k*s;
					if (occ[bj] == occ[bi])
						continue;
					odd = 1'b0;
					for (b = bj + 1; b < bi; b++)
						odd ^= occ[b];
					r = '0;
					r.hop.new_occupation = occ ^ (16'd1 << bj) ^ (16'd1 << bi);
					r.hop.hop_amplitude  = !odd ? a : (a == AMP_MIN) ? AMP_MAX : -a;
					r.hop.from_site      = occ[bj] ? 3'(j) : 3'(i);
					r.hop.to_site        = occ[bj] ? 3'(i) : 3'(j);
					r.hop.spin           = k[0];
					r.hop.found          = 1'b1;
					// keep one back so the final one can carry last
					if (held)
						enqueue_hop(prev);
					prev = r;
					held = 1'b1;
				end
			end
		end
		if (!held)
			prev.hop = HOP_NONE;
		prev.last = 1'b1;
		enqueue_hop(prev);
	endfunction

	function automatic int field_bad(string tag, int want, int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, tag, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (amp_table[e])
				amp_table[e] = '0;
			sites_in_use = 4'd8;
			hops_due.delete();
			errs = 0;
			hops_owed <= 0;
			hop_errors <= 0;
		end else begin
			if (result_valid) begin
				if (hops_due.size() == 0) begin
					$display("%0t ns: unexpected result, expected none, actual occupation %h",
						$time, new_occupation);
					errs++;
				end else begin
					got_hop = hops_due.pop_front();
					errs += field_bad("new_occupation", got_hop.hop.new_occupation,
						new_occupation);
					errs += field_bad("hop_amplitude", got_hop.hop.hop_amplitude,
						hop_amplitude);
					errs += field_bad("from_site", got_hop.hop.from_site, from_site);
					errs += field_bad("to_site", got_hop.hop.to_site, to_site);
					errs += field_bad("spin", got_hop.hop.spin, spin);
					errs += field_bad("found", got_hop.hop.found, found);
					errs += field_bad("last", got_hop.last, last);
				end
			end
			if (cfg_valid && cfg_ready)
				sites_in_use = cfg_data;
			if (start && !busy) begin
				if (opcode_t'(opcode) == OP_LOAD)
					amp_table[table_index] = amplitude;
				else
					predict_hops(occupation);
			end
			hops_owed <= hops_due.size();
			hop_errors <= errs;
		end
	end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives loads and applies into the Hubbard hopping unit over a range of
// site counts, with random idle bursts; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
	import hhop_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               opcode;
	logic [15:0]        occupation;
	logic [5:0]         table_index;
	logic signed [15:0] amplitude;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [3:0]         cfg_data;
	logic               result_valid;
	logic [15:0]        new_occupation;
	logic signed [15:0] hop_amplitude;
	logic [2:0]         from_site;
	logic [2:0]         to_site;
	logic               spin;
	logic               found;
	logic               last;
	int                 hops_owed;
	int                 hop_errors;

	// site counts visited in turn: includes the degenerate 0 and 1, the
	// minimum useful 2, the full 8 and values above 8 that clamp to 8
	logic [3:0] site_plan [0:12] = '{4'd8, 4'd2, 4'd5, 4'd15, 4'd0, 4'd3, 4'd8,
		4'd1, 4'd7, 4'd9, 4'd4, 4'd6, 4'd8};
	int         sites_now;

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	hubbard_hop_with_fermion_sign_top DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.opcode         (opcode),
		.occupation     (occupation),
		.table_index    (table_index),
		.amplitude      (amplitude),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.result_valid   (result_valid),
		.new_occupation (new_occupation),
		.hop_amplitude  (hop_amplitude),
		.from_site      (from_site),
		.to_site        (to_site),
		.spin           (spin),
		.found          (found),
		.last           (last)
	);

	hhop_monitor u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.opcode         (opcode),
		.occupation     (occupation),
		.table_index    (table_index),
		.amplitude      (amplitude),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.result_valid   (result_valid),
		.new_occupation (new_occupation),
		.hop_amplitude  (hop_amplitude),
		.from_site      (from_site),
		.to_site        (to_site),
		.spin           (spin),
		.found          (found),
		.last           (last),
		.hops_owed      (hops_owed),
		.hop_errors     (hop_errors)
	);

	// One command transaction. Fields change at the falling edge; the
	// transaction is taken at the first rising edge that sees busy low.
	// start is left high so a following command goes back to back.
	task automatic send_cmd(opcode_t op, logic [15:0] occ, logic [5:0] idx,
		logic signed [15:0] amp);
		@(negedge clk);
		start       <= 1'b1;
		opcode      <= op;
		occupation  <= occ;
		table_index <= idx;
		amplitude   <= amp;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Idle burst of length n with start low; the fields carry junk so a DUT that
	// samples them without start shows up as a mismatch.
	task automatic pause(int n);
		repeat (n) begin
			@(negedge clk);
			start       <= 1'b0;
			opcode      <= 1'($urandom);
			occupation  <= 16'($urandom);
			table_index <= 6'($urandom);
			amplitude   <= 16'($urandom);
		end
	endtask

	// Hold off until every predicted result is back and the block is idle,
	// and let a scan that gave its last result finish before going on.
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		do
			@(posedge clk);
		while (hops_owed != 0 || busy);
		repeat (4) @(posedge clk);
	endtask

	// active_sites write; only called after drain()
	task automatic write_sites(logic [3:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		sites_now = v;
	endtask

	// amplitude mix: heavy on the saturating minimum, maximum, zero and +-1
	function automatic logic signed [15:0] pick_amp();
		case ($urandom_range(0, 7))
			0:       return AMP_MIN;
			1:       return AMP_MAX;
			2:       return 16'sd0;
			3:       return $urandom_range(0, 1) ? 16'sd1 : -16'sd1;
			default: return 16'($urandom);
		endcase
	endfunction

	// Mostly well-formed traffic: loads aimed at real pairs i<j of the
	// current layout, or applies on sparse, random or one/two-electron words.
	task automatic random_item();
		int          s;
		int          i;
		int          j;
		int          pick;
		logic [5:0]  idx;
		logic [15:0] occ;
		s = (sites_now > 8) ? 8 : sites_now;
		pick = $urandom_range(0, 9);
		if (pick < 4) begin
			if (pick == 0 || s < 2) begin
				idx = 6'($urandom_range(0, 63));
			end else begin
				i = $urandom_range(0, s - 2);
				j = $urandom_range(i + 1, s - 1);
				idx = 6'(i*s + j);
			end
			send_cmd(OP_LOAD, 16'($urandom), idx, pick_amp());
		end else begin
			case ($urandom_range(0, 3))
				0:       occ = 16'($urandom & $urandom);
				1:       occ = (16'd1 << $urandom_range(0, 15)) |
					(16'd1 << $urandom_range(0, 15));
				default: occ = 16'($urandom);
			endcase
			send_cmd(OP_APPLY, occ, 6'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		int gap_odds;
		int n;
		arst_n      = 1'b0;
		start       = 1'b0;
		opcode      = OP_LOAD;
		occupation  = '0;
		table_index = '0;
		amplitude   = '0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		sites_now   = 8;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset layout of 8 sites. Down-spin site n is
		// bit 7-n, up-spin site n is bit 15-n. send_cmd rides out the
		// table clearing pass after reset on busy.
		send_cmd(OP_APPLY, 16'h00ff, 6'd0, 16'sd0);     // cleared table: no hop
		send_cmd(OP_LOAD, 16'h0, 6'd7, AMP_MIN);        // pair 0-7
		send_cmd(OP_LOAD, 16'h0, 6'd1, AMP_MAX);        // pair 0-1
		send_cmd(OP_LOAD, 16'h0, 6'd21, -16'sd1);       // pair 2-5
		send_cmd(OP_LOAD, 16'h0, 6'd28, 16'sh1234);     // pair 3-4
		send_cmd(OP_LOAD, 16'h0, 6'd63, 16'sd1);        // diagonal, never read
		send_cmd(OP_LOAD, 16'h0, 6'd8, 16'sd5);         // lower triangle, never read
		send_cmd(OP_APPLY, 16'h0000, 6'd0, 16'sd0);     // empty lattice
		send_cmd(OP_APPLY, 16'hffff, 6'd0, 16'sd0);     // full lattice
		send_cmd(OP_APPLY, 16'h0080, 6'd0, 16'sd0);     // lone site 0 down
		send_cmd(OP_APPLY, 16'h0082, 6'd0, 16'sd0);     // odd parity on 0-7: saturate
		send_cmd(OP_APPLY, 16'h8200, 6'd0, 16'sd0);     // same on the up half
		send_cmd(OP_APPLY, 16'h0001, 6'd0, 16'sd0);     // hop toward lower site
		send_cmd(OP_APPLY, 16'h3030, 6'd0, 16'sd0);     // both spins hop on two pairs
		send_cmd(OP_LOAD, 16'h0, 6'd7, 16'sd0);         // clear an entry again
		send_cmd(OP_APPLY, 16'h0082, 6'd0, 16'sd0);
		send_cmd(OP_LOAD, 16'h0, 6'd7, AMP_MIN);
		send_cmd(OP_APPLY, 16'h8282, 6'd0, 16'sd0);     // saturate on both spins
		send_cmd(OP_APPLY, 16'h5a5a, 6'd0, 16'sd0);

		// Random phases, one per site count. Each starts drained, which is
		// also where the sender waits out every outstanding result. The
		// final phase runs with no idling at all.
		foreach (site_plan[p]) begin
			drain();
			write_sites(site_plan[p]);
			gap_odds = (p == 12) ? 0 : $urandom_range(0, 3);
			for (n = 0; n < 32; n++) begin
				random_item();
				if (gap_odds != 0 && $urandom_range(1, 4) <= gap_odds)
					pause($urandom_range(1, 18));
			end
		end

		drain();
		repeat (64) @(posedge clk);
		if (hop_errors == 0 && hops_owed == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// watchdog: the slowest legal run is under a tenth of this
	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

// ===== hubbard_hop_with_fermion_sign_top.f =====
hw/rtl/hhop_pkg.sv
hw/rtl/hhop_eval.sv
hw/rtl/hubbard_hop_with_fermion_sign_top.sv
hw/rtl/hhop_checker.sv
dv/hhop_checker.sv
dv/tb.sv
